/* hw/rtl/apc_pkg.sv */
// apc_pkg: shared types, constants and the palette rom for the angle palette colorizer
// depends on nothing; every other file of the block imports it
package apc_pkg;

  // cordic sizing
  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  // 32-bit point scaled by 2^24, plus headroom for cordic gain and a negation
  localparam int PRESCALE     = 24;
  localparam int CORDIC_W     = 60;

  // palette
  localparam int PAL_SIZE              = 17;
  localparam logic [4:0]  PAL_LAST     = 5'(PAL_SIZE - 1);
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // input and result items
  typedef struct packed {
    logic [9:0]         row;
    logic [9:0]         col;
    logic signed [31:0] orbit_x;
    logic signed [31:0] orbit_y;
  } apc_in_t;

  typedef struct packed {
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } apc_out_t;

  // state carried through the cordic stages
  typedef struct packed {
    logic [9:0]                 row;
    logic [9:0]                 col;
    logic                       zero;
    logic signed [CORDIC_W-1:0] re;
    logic signed [CORDIC_W-1:0] im;
    logic [31:0]                acc;
  } apc_cd_t;

  // colour triple: [2] red, [1] green, [0] blue
  typedef logic [2:0][15:0] apc_rgb_t;

  // palette rom, q0.16 components
  function automatic apc_rgb_t pal_rom(input logic [4:0] idx);
    apc_rgb_t e;
    case (idx)
      5'd0:    e = {16'd0,     16'd0,     16'd0};
      5'd1:    e = {16'd13107, 16'd13107, 16'd6554};
      5'd2:    e = {16'd6554,  16'd0,     16'd6554};
      5'd3:    e = {16'd0,     16'd0,     16'd13107};
      5'd4:    e = {16'd0,     16'd0,     16'd19661};
      5'd5:    e = {16'd0,     16'd0,     16'd26214};
      5'd6:    e = {16'd0,     16'd13107, 16'd32768};
      5'd7:    e = {16'd6554,  16'd19661, 16'd45875};
      5'd8:    e = {16'd13107, 16'd32768, 16'd52428};
      5'd9:    e = {16'd32768, 16'd45875, 16'd58982};
      5'd10:   e = {16'd52428, 16'd58982, 16'd65535};
      5'd11:   e = {16'd58982, 16'd58982, 16'd45875};
      5'd12:   e = {16'd65535, 16'd52428, 16'd26214};
      5'd13:   e = {16'd65535, 16'd45875, 16'd0};
      5'd14:   e = {16'd52428, 16'd32768, 16'd0};
      5'd15:   e = {16'd39321, 16'd19661, 16'd0};
      5'd16:   e = {16'd26214, 16'd13107, 16'd0};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

/* hw/rtl/apc_pre.sv */
// apc_pre: input register stage, scales the orbit point and folds the left half-plane
// depends on apc_pkg
module apc_pre (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  apc_pkg::apc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output apc_pkg::apc_cd_t out_data
);
  import apc_pkg::*;

  logic                       vld_r;
  apc_cd_t                    st_r;
  apc_cd_t                    st_nxt;
  logic signed [CORDIC_W-1:0] re_s;
  logic signed [CORDIC_W-1:0] im_s;
  logic                       neg;

  // stage takes an item when empty or when its content moves on
  assign in_ready = !vld_r || out_ready;

  // scale the point, real part is y and imaginary part is x
  always_comb begin
    re_s = CORDIC_W'(in_data.orbit_y) <<< PRESCALE;
    im_s = CORDIC_W'(in_data.orbit_x) <<< PRESCALE;
    neg  = in_data.orbit_y[31];
    st_nxt.row  = in_data.row;
    st_nxt.col  = in_data.col;
    st_nxt.zero = (in_data.orbit_x == '0) && (in_data.orbit_y == '0);
    st_nxt.re   = neg ? -re_s : re_s;
    st_nxt.im   = neg ? -im_s : im_s;
    st_nxt.acc  = neg ? HALF_TURN : '0;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = st_r;

endmodule

/* hw/rtl/apc_cordic.sv */
// apc_cordic: vectoring cordic, one rotation per register stage
// depends on apc_pkg
module apc_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  apc_pkg::apc_cd_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output apc_pkg::apc_cd_t out_data
);
  import apc_pkg::*;

  apc_cd_t st_r  [CORDIC_N];
  logic    vld_r [CORDIC_N];
  logic    rdy   [CORDIC_N+1];

  assign rdy[CORDIC_N] = out_ready;
  assign in_ready      = rdy[0];

  for (genvar g = 0; g < CORDIC_N; g++) begin : g_step
    apc_cd_t prv;
    logic    prv_v;
    apc_cd_t st_nxt;

    // source of this stage
    if (g == 0) begin : g_first
      assign prv   = in_data;
      assign prv_v = in_valid;
    end else begin : g_next
      assign prv   = st_r[g-1];
      assign prv_v = vld_r[g-1];
    end

    assign rdy[g] = !vld_r[g] || rdy[g+1];

    // rotate toward the real axis, sign of the imaginary part decides
    always_comb begin
      st_nxt = prv;
      if (!prv.im[CORDIC_W-1]) begin
        st_nxt.re  = prv.re + (prv.im >>> g);
        st_nxt.im  = prv.im - (prv.re >>> g);
        st_nxt.acc = prv.acc + ATAN_TURNS[g];
      end else begin
        st_nxt.re  = prv.re - (prv.im >>> g);
        st_nxt.im  = prv.im + (prv.re >>> g);
        st_nxt.acc = prv.acc - ATAN_TURNS[g];
      end
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld_r[g] <= prv_v;
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        st_r[g] <= st_nxt;
      end
    end
  end

  assign out_valid = vld_r[CORDIC_N-1];
  assign out_data  = st_r[CORDIC_N-1];

endmodule

/* hw/rtl/apc_color.sv */
// apc_color: phase to palette position, rom lookup and linear blend, three stages
// depends on apc_pkg
module apc_color (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  apc_pkg::apc_cd_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output apc_pkg::apc_out_t out_data
);
  import apc_pkg::*;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [4:0]  ent;
    logic [15:0] frac;
  } pos_t;

  typedef struct packed {
    logic [9:0]       row;
    logic [9:0]       col;
    apc_rgb_t         base;
    logic [2:0][33:0] prod;
  } mix_t;

  logic     pos_v_r;
  pos_t     pos_r;
  pos_t     pos_nxt;
  logic     mix_v_r;
  mix_t     mix_r;
  mix_t     mix_nxt;
  logic     res_v_r;
  apc_out_t res_r;
  apc_out_t res_nxt;
  logic     pos_rdy;
  logic     mix_rdy;
  logic     res_rdy;

  logic [31:0]        phase;
  logic [31:0]        u;
  logic [36:0]        scaled;
  logic [4:0]         ent2;
  apc_rgb_t           c1;
  apc_rgb_t           c2;
  logic signed [16:0] diff;
  logic signed [33:0] prd;
  logic [33:0]        rnd;
  logic [17:0]        sum;

  // ready chain
  assign res_rdy  = !res_v_r || out_ready;
  assign mix_rdy  = !mix_v_r || res_rdy;
  assign pos_rdy  = !pos_v_r || mix_rdy;
  assign in_ready = pos_rdy;

  // palette position: (phase + half turn) * 17 in 5.16
  always_comb begin
    phase  = in_data.zero ? '0 : in_data.acc;
    u      = phase + HALF_TURN;
    scaled = 37'(u) * 37'(PAL_SIZE);
    pos_nxt.row  = in_data.row;
    pos_nxt.col  = in_data.col;
    pos_nxt.ent  = scaled[36:32];
    pos_nxt.frac = scaled[31:16];
  end

  // rom lookup, difference times fraction per channel
  always_comb begin
    ent2 = (pos_r.ent == PAL_LAST) ? '0 : pos_r.ent + 5'd1;
    c1   = pal_rom(pos_r.ent);
    c2   = pal_rom(ent2);
    mix_nxt.row  = pos_r.row;
    mix_nxt.col  = pos_r.col;
    mix_nxt.base = c1;
    mix_nxt.prod = '0;
    diff = '0;
    prd  = '0;
    for (int c = 0; c < 3; c++) begin
      diff = signed'({1'b0, c2[c]}) - signed'({1'b0, c1[c]});
      prd  = 34'(diff) * signed'(34'({1'b0, pos_r.frac}));
      mix_nxt.prod[c] = prd;
    end
  end

  // round and add the base entry
  always_comb begin
    res_nxt.out_row = mix_r.row;
    res_nxt.out_col = mix_r.col;
    res_nxt.red     = '0;
    res_nxt.green   = '0;
    res_nxt.blue    = '0;
    rnd = '0;
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      rnd = mix_r.prod[c] + 34'd32768;
      sum = {2'b00, mix_r.base[c]} + rnd[33:16];
      case (c)
        2:       res_nxt.red   = sum[15:0];
        1:       res_nxt.green = sum[15:0];
        default: res_nxt.blue  = sum[15:0];
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_v_r <= 1'b0;
      mix_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (pos_rdy) begin
        pos_v_r <= in_valid;
      end
      if (mix_rdy) begin
        mix_v_r <= pos_v_r;
      end
      if (res_rdy) begin
        res_v_r <= mix_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pos_rdy) begin
      pos_r <= pos_nxt;
    end
    if (mix_rdy) begin
      mix_r <= mix_nxt;
    end
    if (res_rdy) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

endmodule

/* hw/rtl/angle_palette_colorizer_top.sv */
// angle_palette_colorizer_top: colours a pixel from the angle of its final orbit point
// depends on apc_pkg, apc_pre, apc_cordic, apc_color
//
// Usage:
//   in channel  (in_valid / in_ready / in_data): one pixel item, row, column and
//   the signed orbit point (orbit_x, orbit_y).
//   out channel (out_valid / out_ready / out_data): one colour item per pixel,
//   row and column unchanged, red / green / blue in q0.16, in input order.
//   The pipe has 22 register stages: one input stage, one stage per cordic rotation
//   (18), then position, rom blend and rounding stages. Throughput is one item per
//   cycle while out_ready is high or bubbles remain; every stage is a plain register,
//   so the length of the cordic chain sets the latency and only back-pressure from
//   out_ready limits the rate.
//   Each stage has its own valid bit and takes a new item when it is empty or
//   its content moves on, so while out_ready is low the pipe keeps accepting
//   until its bubbles are filled; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; in_ready is high
//   right after reset. There is no configuration and no state between items.
module angle_palette_colorizer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  apc_pkg::apc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output apc_pkg::apc_out_t out_data
);
  import apc_pkg::*;

  apc_cd_t pre_data;
  logic    pre_valid;
  logic    pre_ready;
  apc_cd_t cd_data;
  logic    cd_valid;
  logic    cd_ready;

  // scale and fold
  apc_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (pre_valid),
    .out_ready (pre_ready),
    .out_data  (pre_data)
  );

  // angle
  apc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pre_valid),
    .in_ready  (pre_ready),
    .in_data   (pre_data),
    .out_valid (cd_valid),
    .out_ready (cd_ready),
    .out_data  (cd_data)
  );

  // palette blend
  apc_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cd_valid),
    .in_ready  (cd_ready),
    .in_data   (cd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/apc_checker.sv */
// apc_checker: port-level checks for the angle palette colorizer, bound to the top level
// depends on apc_pkg and angle_palette_colorizer_top
module apc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input apc_pkg::apc_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input apc_pkg::apc_out_t out_data
);
  import apc_pkg::*;

  // a waiting input item stays offered with its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("in item changed while waiting");

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out item dropped while stalled");

  // a stalled item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out item changed while stalled");

  // a free receiver always frees the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind angle_palette_colorizer_top apc_checker u_apc_checker (.*);
